@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the token lexer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define TL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("token lexer assertion failed");
// Next-cycle implication, checked at every rising clock edge out of reset.
`define TL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("token lexer assertion failed");
`else
`define TL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/tl_pkg.sv @@
// ----------------------------------------------------------------------------
// Token lexer package
// Types, token kind codes, scan modes and the keyword table of the lexer.
// ----------------------------------------------------------------------------
package tl_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned KEYWORD_CHARS_DEF = 8;
  localparam int unsigned COUNT_BITS_DEF    = 16;

  // Fixed field widths of the channels.
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned KIND_W = 5;
  localparam int unsigned POS_W  = 16;

  // Depth of the result queue; a power of two so the pointers wrap freely.
  localparam int unsigned FIFO_DEPTH = 4;

  // Token kind codes.
  localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd0;
  localparam logic [KIND_W-1:0] KIND_INT    = 5'd1;
  localparam logic [KIND_W-1:0] KIND_STRING = 5'd2;
  localparam logic [KIND_W-1:0] KIND_IF     = 5'd3;
  localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd10;
  localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd11;
  localparam logic [KIND_W-1:0] KIND_STAR   = 5'd12;
  localparam logic [KIND_W-1:0] KIND_SLASH  = 5'd13;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd14;
  localparam logic [KIND_W-1:0] KIND_EQ     = 5'd15;
  localparam logic [KIND_W-1:0] KIND_NE     = 5'd16;
  localparam logic [KIND_W-1:0] KIND_LT     = 5'd17;
  localparam logic [KIND_W-1:0] KIND_LE     = 5'd18;
  localparam logic [KIND_W-1:0] KIND_GT     = 5'd19;
  localparam logic [KIND_W-1:0] KIND_GE     = 5'd20;
  localparam logic [KIND_W-1:0] KIND_AND    = 5'd21;
  localparam logic [KIND_W-1:0] KIND_OR     = 5'd22;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd23;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd24;
  localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd25;
  localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd26;
  localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd27;
  localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd28;
  localparam logic [KIND_W-1:0] KIND_END    = 5'd29;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 5'd30;

  // Characters with a role in the scanner.
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;
  localparam logic [CHAR_W-1:0] CH_PIPE  = 8'h7C;

  // Keyword table; each spelling is right-justified in its 64-bit word.
  localparam int unsigned KW_NUM = 7;
  localparam int unsigned KW_MAX = 8;
  localparam logic [KW_MAX*CHAR_W-1:0] KW_TEXT [KW_NUM] = '{
    "if", "while", "else", "function", "var", "printf", "return"
  };
  localparam int unsigned KW_LEN [KW_NUM] = '{2, 5, 4, 8, 3, 6, 6};

  // Scan modes of the lexer.
  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_EQUAL,
    MODE_BANG,
    MODE_LESS,
    MODE_GREATER,
    MODE_AMP,
    MODE_PIPE
  } mode_e;

  // One result word, text echo or token record.
  typedef struct packed {
    logic              is_text;
    logic [CHAR_W-1:0] text_byte;
    logic [KIND_W-1:0] token_kind;
    logic [POS_W-1:0]  start_line;
    logic [POS_W-1:0]  start_column;
    logic [POS_W-1:0]  token_length;
    logic              last;
  } result_t;

  // Results caused by one input word, handed to the result queue.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Character j of keyword k, first character at j = 0.
  function automatic logic [CHAR_W-1:0] kw_char(input int k, input int j);
    if (j < int'(KW_LEN[k])) begin
      return KW_TEXT[k][CHAR_W*(int'(KW_LEN[k])-1-j) +: CHAR_W];
    end
    return '0;
  endfunction

  // Clip a count to the 16-bit output range.
  function automatic logic [POS_W-1:0] clip16(input logic [31:0] v);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[POS_W-1:0];
  endfunction

  // Text echo word.
  function automatic result_t mk_text(input logic [CHAR_W-1:0] c);
    result_t r;
    r           = '0;
    r.is_text   = 1'b1;
    r.text_byte = c;
    return r;
  endfunction

  // Token record word.
  function automatic result_t mk_rec(input logic [KIND_W-1:0] kind,
                                     input logic [POS_W-1:0] line,
                                     input logic [POS_W-1:0] col,
                                     input logic [POS_W-1:0] len);
    result_t r;
    r              = '0;
    r.token_kind   = kind;
    r.start_line   = line;
    r.start_column = col;
    r.token_length = len;
    return r;
  endfunction

endpackage

@@ sv/tl_char_if.sv @@
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel that carries one source byte or an end mark per word.
// ----------------------------------------------------------------------------
interface tl_char_if;
  import tl_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic              end_of_input;

  modport source (output valid, char_byte, end_of_input, input ready);
  modport sink   (input valid, char_byte, end_of_input, output ready);
endinterface

@@ sv/tl_token_if.sv @@
// ----------------------------------------------------------------------------
// Token channel
// Valid/ready channel that carries one text echo or token record per word.
// ----------------------------------------------------------------------------
interface tl_token_if;
  import tl_pkg::*;

  logic              valid;
  logic              ready;
  logic              is_text;
  logic [CHAR_W-1:0] text_byte;
  logic [KIND_W-1:0] token_kind;
  logic [POS_W-1:0]  start_line;
  logic [POS_W-1:0]  start_column;
  logic [POS_W-1:0]  token_length;
  logic              last;

  modport source (output valid, is_text, text_byte, token_kind, start_line,
                  start_column, token_length, last, input ready);
  modport sink   (input valid, is_text, text_byte, token_kind, start_line,
                  start_column, token_length, last, output ready);
endinterface

@@ sv/tl_lex_core.sv @@
// ----------------------------------------------------------------------------
// Token lexer core
// Scanner state and the per-byte logic that yields up to two results.
// ----------------------------------------------------------------------------
module tl_lex_core #(
  parameter int unsigned KEYWORD_CHARS = tl_pkg::KEYWORD_CHARS_DEF,
  parameter int unsigned COUNT_BITS    = tl_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic [tl_pkg::CHAR_W-1:0] char_byte_i,
  input  logic                      end_of_input_i,
  output tl_pkg::push_t             push_o
);
  import tl_pkg::*;

  localparam int unsigned IDX_W = $clog2(KEYWORD_CHARS);

  typedef logic [COUNT_BITS-1:0] cnt_t;

  // Saturating increment of a scanner counter.
  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  mode_e             mode_q, mode_d;
  cnt_t              line_q, line_d;
  cnt_t              col_q, col_d;
  cnt_t              tok_line_q, tok_line_d;
  cnt_t              tok_col_q, tok_col_d;
  cnt_t              cnt_q, cnt_d;
  logic [CHAR_W-1:0] buf_q [KEYWORD_CHARS];

  logic              buf_we;
  logic [IDX_W-1:0]  buf_idx;

  logic [CHAR_W-1:0] c_eff;
  logic              c_alpha, c_digit, c_space;
  cnt_t              line_n, col_n;
  logic [POS_W-1:0]  cnt16, line_n16, col_n16;

  logic              kw_found;
  logic [KIND_W-1:0] kw_kind;
  logic [POS_W-1:0]  kw_len16;

  mode_e             id_mode;
  logic              id_emit, id_text;
  logic [KIND_W-1:0] id_kind;

  logic              pend_valid;
  logic [KIND_W-1:0] pend_kind;
  logic [POS_W-1:0]  pend_len;

  logic              cont, close;
  logic [KIND_W-1:0] close_kind;
  logic [POS_W-1:0]  close_len;

  // Character classes and the updated line and column.
  always_comb begin
    c_eff    = (char_byte_i == CH_LF) ? CH_SPACE : char_byte_i;
    c_alpha  = (c_eff >= "a" && c_eff <= "z") || (c_eff >= "A" && c_eff <= "Z");
    c_digit  = (c_eff >= "0" && c_eff <= "9");
    c_space  = (c_eff == CH_SPACE) || (c_eff >= CH_TAB && c_eff <= CH_CR);
    line_n   = (char_byte_i == CH_LF) ? sat_inc(line_q) : line_q;
    col_n    = (char_byte_i == CH_LF) ? '0 : sat_inc(col_q);
    cnt16    = clip16(32'(cnt_q));
    line_n16 = clip16(32'(line_n));
    col_n16  = clip16(32'(col_n));
  end

  // Keyword lookup on the buffered word; lengths differ or text differs.
  always_comb begin
    logic hit;
    kw_found = 1'b0;
    kw_kind  = KIND_IDENT;
    kw_len16 = '0;
    for (int k = 0; k < KW_NUM; k++) begin
      hit = (cnt_q == cnt_t'(KW_LEN[k]));
      for (int j = 0; j < KW_MAX; j++) begin
        if (j < int'(KW_LEN[k]) && buf_q[j] != kw_char(k, j)) begin
          hit = 1'b0;
        end
      end
      if (hit && !kw_found) begin
        kw_found = 1'b1;
        kw_kind  = KIND_IF + KIND_W'(k);
        kw_len16 = POS_W'(KW_LEN[k]);
      end
    end
  end

  // What a byte does when no token is open.
  always_comb begin
    id_mode = MODE_IDLE;
    id_emit = 1'b0;
    id_text = 1'b0;
    id_kind = KIND_ERROR;
    if (!c_space) begin
      if (c_alpha) begin
        id_mode = MODE_IDENT;
        id_emit = 1'b1;
        id_text = 1'b1;
      end else if (c_digit) begin
        id_mode = MODE_NUMBER;
        id_emit = 1'b1;
        id_text = 1'b1;
      end else begin
        id_emit = 1'b1;
        unique case (c_eff)
          CH_QUOTE: begin id_mode = MODE_STRING;  id_emit = 1'b0; end
          CH_EQUAL: begin id_mode = MODE_EQUAL;   id_emit = 1'b0; end
          "!":      begin id_mode = MODE_BANG;    id_emit = 1'b0; end
          "<":      begin id_mode = MODE_LESS;    id_emit = 1'b0; end
          ">":      begin id_mode = MODE_GREATER; id_emit = 1'b0; end
          CH_AMP:   begin id_mode = MODE_AMP;     id_emit = 1'b0; end
          CH_PIPE:  begin id_mode = MODE_PIPE;    id_emit = 1'b0; end
          "+":      id_kind = KIND_PLUS;
          "-":      id_kind = KIND_MINUS;
          "*":      id_kind = KIND_STAR;
          "/":      id_kind = KIND_SLASH;
          "(":      id_kind = KIND_LPAREN;
          ")":      id_kind = KIND_RPAREN;
          "{":      id_kind = KIND_LBRACE;
          "}":      id_kind = KIND_RBRACE;
          ",":      id_kind = KIND_COMMA;
          ";":      id_kind = KIND_SEMI;
          default:  id_kind = KIND_ERROR;
        endcase
      end
    end
  end

  // Record that the open token gives when something else ends it.
  always_comb begin
    pend_valid = 1'b1;
    pend_kind  = KIND_ERROR;
    pend_len   = POS_W'(1);
    unique case (mode_q)
      MODE_IDENT: begin
        pend_kind = kw_found ? kw_kind : KIND_IDENT;
        pend_len  = kw_found ? kw_len16 : cnt16;
      end
      MODE_NUMBER:  begin pend_kind = KIND_INT;   pend_len = cnt16; end
      MODE_STRING:  begin pend_kind = KIND_ERROR; pend_len = cnt16; end
      MODE_EQUAL:   pend_kind = KIND_ASSIGN;
      MODE_LESS:    pend_kind = KIND_LT;
      MODE_GREATER: pend_kind = KIND_GT;
      MODE_BANG, MODE_AMP, MODE_PIPE: pend_kind = KIND_ERROR;
      default:      pend_valid = 1'b0;
    endcase
  end

  // Does the byte extend the open token, or close it by itself?
  always_comb begin
    cont       = 1'b0;
    close      = 1'b0;
    close_kind = KIND_STRING;
    close_len  = POS_W'(2);
    unique case (mode_q)
      MODE_IDENT:  cont = c_alpha || c_digit;
      MODE_NUMBER: cont = c_digit;
      MODE_STRING: begin
        close     = (c_eff == CH_QUOTE);
        cont      = !close;
        close_len = cnt16;
      end
      MODE_EQUAL:   begin close = (c_eff == CH_EQUAL); close_kind = KIND_EQ; end
      MODE_BANG:    begin close = (c_eff == CH_EQUAL); close_kind = KIND_NE; end
      MODE_LESS:    begin close = (c_eff == CH_EQUAL); close_kind = KIND_LE; end
      MODE_GREATER: begin close = (c_eff == CH_EQUAL); close_kind = KIND_GE; end
      MODE_AMP:     begin close = (c_eff == CH_AMP);   close_kind = KIND_AND; end
      MODE_PIPE:    begin close = (c_eff == CH_PIPE);  close_kind = KIND_OR; end
      default: ;
    endcase
  end

  // Next scanner state.
  always_comb begin
    mode_d     = mode_q;
    line_d     = line_q;
    col_d      = col_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    cnt_d      = cnt_q;
    buf_we     = 1'b0;
    buf_idx    = cnt_q[IDX_W-1:0];
    if (fire_i) begin
      if (end_of_input_i) begin
        mode_d = MODE_IDLE;
      end else begin
        line_d = line_n;
        col_d  = col_n;
        if (cont) begin
          cnt_d  = sat_inc(cnt_q);
          buf_we = (mode_q == MODE_IDENT) && (cnt_q < cnt_t'(KEYWORD_CHARS));
        end else if (close) begin
          mode_d = MODE_IDLE;
        end else begin
          mode_d = id_mode;
          if (!c_space) begin
            tok_line_d = line_n;
            tok_col_d  = col_n;
          end
          if (c_alpha || c_digit) begin
            cnt_d = cnt_t'(1);
          end else if (id_mode == MODE_STRING) begin
            cnt_d = '0;
          end
          if (c_alpha) begin
            buf_we  = 1'b1;
            buf_idx = '0;
          end
        end
      end
    end
  end

  // Results of this byte, packed from the front.
  always_comb begin
    logic             a_v, b_v;
    result_t          a, b;
    logic [POS_W-1:0] tl16, tc16;
    tl16 = clip16(32'(tok_line_q));
    tc16 = clip16(32'(tok_col_q));
    a_v  = 1'b0;
    b_v  = 1'b0;
    a    = mk_rec(pend_kind, tl16, tc16, pend_len);
    b    = mk_text(c_eff);
    if (end_of_input_i) begin
      a_v = pend_valid;
      b_v = 1'b1;
      b   = mk_rec(KIND_END, clip16(32'(line_q)), clip16(32'(col_q)), '0);
    end else if (cont) begin
      a_v = 1'b1;
      a   = mk_text(c_eff);
    end else if (close) begin
      a_v = 1'b1;
      a   = mk_rec(close_kind, tl16, tc16, close_len);
    end else begin
      a_v = pend_valid;
      b_v = id_emit;
      if (!id_text) begin
        b = mk_rec(id_kind, line_n16, col_n16, POS_W'(1));
      end
    end
    b.last       = 1'b1;
    push_o.count = fire_i ? (2'(a_v) + 2'(b_v)) : 2'd0;
    push_o.r0    = a_v ? a : b;
    push_o.r1    = b;
    push_o.r0.last = !(a_v && b_v);
  end

  // Scanner registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      line_q     <= cnt_t'(1);
      col_q      <= '0;
      tok_line_q <= '0;
      tok_col_q  <= '0;
      cnt_q      <= '0;
    end else begin
      mode_q     <= mode_d;
      line_q     <= line_d;
      col_q      <= col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      cnt_q      <= cnt_d;
    end
  end

  // Word buffer for the keyword check; only entries of the open word are read.
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_q[buf_idx] <= c_eff;
    end
  end

endmodule

@@ sv/tl_result_fifo.sv @@
// ----------------------------------------------------------------------------
// Token lexer result queue
// Small queue that takes up to two result words a cycle and emits one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tl_result_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tl_pkg::push_t   push_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tl_pkg::result_t out_data_o
);
  import tl_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;
  localparam logic [CNT_W-1:0] ROOM_CNT = CNT_W'(FIFO_DEPTH - 2);

  result_t          mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  // Room for a full pair of results keeps the input side open.
  assign in_ready_o  = (cnt_q <= ROOM_CNT);
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    cnt_d    = cnt_q + CNT_W'(push_i.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage; the second word of a pair lands behind the first.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= push_i.r1;
    end
  end

  // Results are only pushed while a full pair still fits.
  `TL_ASSERT_IMPLY(a_push_room, clk_i, rst_ni, push_i.count != 2'd0, cnt_q <= ROOM_CNT)
  // Occupancy tracks the pointer distance.
  `TL_ASSERT_IMPLY(a_cnt_ptr, clk_i, rst_ni, 1'b1, cnt_q[PTR_W-1:0] == wr_ptr_q - rd_ptr_q)
  // Only the final word of a pair carries the last flag.
  `TL_ASSERT_IMPLY(a_last_pair, clk_i, rst_ni, push_i.count == 2'd2, !push_i.r0.last && push_i.r1.last)
  // A lone word is always the last of its byte.
  `TL_ASSERT_IMPLY(a_last_one, clk_i, rst_ni, push_i.count == 2'd1, push_i.r0.last)

endmodule

@@ sv/token_lexer_top.sv @@
// ----------------------------------------------------------------------------
// Token lexer top level
// Streaming lexer: source bytes in, text echoes and token records out.
// ----------------------------------------------------------------------------
// Usage:
//   char_i takes one word per handshake: a source byte, or an end mark when
//   end_of_input is set. token_o gives one word per handshake: a text echo
//   of an identifier, number or string character, or a token record with
//   kind, start line, start column and length. The last flag marks the
//   final word caused by one input word; a byte may cause none.
//   An accepted word's results are written into the result queue and
//   reach token_o behind older words. The scanner takes one byte a cycle
//   while char_i.ready is high; two results of a byte leave one at a time,
//   and the four-entry result queue admits a byte while it has room for two.
//   With at most one result per byte and no output stall, that rate holds.
//   When the receiver stalls, the queue fills and char_i.ready drops once
//   fewer than two entries are free; nothing is lost.
//   Reset empties the queue, sets the line count to one, the column to zero
//   and the scanner to idle. No clearing pass is needed.
// ----------------------------------------------------------------------------
module token_lexer_top #(
  parameter int unsigned KEYWORD_CHARS = tl_pkg::KEYWORD_CHARS_DEF,
  parameter int unsigned COUNT_BITS    = tl_pkg::COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tl_char_if.sink    char_i,
  tl_token_if.source token_o
);
  import tl_pkg::*;

  push_t   push;
  result_t head;
  logic    fire;
  logic    in_ready;

  // Input handshake.
  assign char_i.ready = in_ready;
  assign fire         = char_i.valid && in_ready;

  tl_lex_core #(
    .KEYWORD_CHARS (KEYWORD_CHARS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .char_byte_i    (char_i.char_byte),
    .end_of_input_i (char_i.end_of_input),
    .push_o         (push)
  );

  tl_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_ready_o  (in_ready),
    .out_valid_o (token_o.valid),
    .out_ready_i (token_o.ready),
    .out_data_o  (head)
  );

  // Output payload from the queue head.
  assign token_o.is_text      = head.is_text;
  assign token_o.text_byte    = head.text_byte;
  assign token_o.token_kind   = head.token_kind;
  assign token_o.start_line   = head.start_line;
  assign token_o.start_column = head.start_column;
  assign token_o.token_length = head.token_length;
  assign token_o.last         = head.last;

endmodule
